/* src/lsm_pkg.sv */
// lsm_pkg: word types, opcodes and control codes for the LRU slot manager.
// No dependencies; used by every file under src.
`default_nettype none
package lsm_pkg;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int OFF_W  = 48;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_TOUCH = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PROMOTE,
    ACT_REMOVE
  } act_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        slot_index;
    logic signed [OFF_W-1:0] page_offset;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        result_slot;
    logic                    evicted;
    logic signed [OFF_W-1:0] evicted_offset;
    logic                    status;
  } out_word_t;

  typedef struct packed {
    logic eval;
    logic apply;
    act_t act;
    logic by_key;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* src/lsm_cell.sv */
// lsm_cell: one position of the recency row (head at position 0).
// Holds slot id and tag; shifts from either neighbor. Uses lsm_pkg.
`default_nettype none
module lsm_cell #(
  parameter int CELL_IDX = 0,
  parameter int SLOT_W   = 4,
  parameter int TAG_W    = 48,
  parameter int CNT_W    = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lsm_pkg::cell_ctl_t ctl,
  input  wire logic [SLOT_W-1:0] key_id,
  input  wire logic [CNT_W-1:0]  pos,
  input  wire logic              prev_valid,
  input  wire logic [SLOT_W-1:0] prev_id,
  input  wire logic [TAG_W-1:0]  prev_tag,
  input  wire logic              next_valid,
  input  wire logic [SLOT_W-1:0] next_id,
  input  wire logic [TAG_W-1:0]  next_tag,
  input  wire logic              seen_in,
  output logic                   seen_out,
  input  wire logic [SLOT_W-1:0] sel_id_in,
  input  wire logic [TAG_W-1:0]  sel_tag_in,
  output logic      [SLOT_W-1:0] sel_id_out,
  output logic      [TAG_W-1:0]  sel_tag_out,
  output logic                   valid,
  output logic      [SLOT_W-1:0] id,
  output logic      [TAG_W-1:0]  tag
);

  logic              valid_r;
  logic              target_r;
  logic              target_nxt;
  logic [SLOT_W-1:0] id_r;
  logic [TAG_W-1:0]  tag_r;
  logic              take_prev;
  logic              take_next;

  always_comb begin
    if (ctl.by_key) begin
      target_nxt = valid_r && (id_r == key_id);
    end else begin
      target_nxt = (pos == CNT_W'(CELL_IDX));
    end
    take_prev = ctl.apply && (ctl.act == lsm_pkg::ACT_PROMOTE) && !seen_in;
    take_next = ctl.apply && (ctl.act == lsm_pkg::ACT_REMOVE) && (seen_in || target_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      target_r <= 1'b0;
    end else begin
      if (ctl.eval) begin
        target_r <= target_nxt;
      end
      if (take_prev) begin
        valid_r <= prev_valid;
      end else if (take_next) begin
        valid_r <= next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_prev) begin
      id_r  <= prev_id;
      tag_r <= prev_tag;
    end else if (take_next) begin
      id_r  <= next_id;
      tag_r <= next_tag;
    end
  end

  assign seen_out    = seen_in | target_r;
  assign sel_id_out  = sel_id_in | (target_r ? id_r : '0);
  assign sel_tag_out = sel_tag_in | (target_r ? tag_r : '0);
  assign valid       = valid_r;
  assign id          = id_r;
  assign tag         = tag_r;

endmodule
`default_nettype wire

/* src/lsm_row.sv */
// lsm_row: chain of lsm_cell instances, head first.
// Returns the marked cell's id and tag. Uses lsm_pkg and lsm_cell.
`default_nettype none
module lsm_row #(
  parameter int NUM_SLOTS = 16,
  parameter int SLOT_W    = 4,
  parameter int TAG_W     = 48,
  parameter int CNT_W     = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lsm_pkg::cell_ctl_t ctl,
  input  wire logic [SLOT_W-1:0]  key_id,
  input  wire logic [CNT_W-1:0]   pos,
  input  wire logic [SLOT_W-1:0]  head_id,
  input  wire logic [TAG_W-1:0]   head_tag,
  output logic                    found,
  output logic      [SLOT_W-1:0]  sel_id,
  output logic      [TAG_W-1:0]   sel_tag
);

  logic              seen  [NUM_SLOTS+1];
  logic [SLOT_W-1:0] sid   [NUM_SLOTS+1];
  logic [TAG_W-1:0]  stag  [NUM_SLOTS+1];
  logic              c_vld [NUM_SLOTS];
  logic [SLOT_W-1:0] c_id  [NUM_SLOTS];
  logic [TAG_W-1:0]  c_tag [NUM_SLOTS];

  assign seen[0] = 1'b0;
  assign sid[0]  = '0;
  assign stag[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    logic              p_vld;
    logic [SLOT_W-1:0] p_id;
    logic [TAG_W-1:0]  p_tag;
    logic              n_vld;
    logic [SLOT_W-1:0] n_id;
    logic [TAG_W-1:0]  n_tag;

    if (i == 0) begin : g_head
      assign p_vld = 1'b1;
      assign p_id  = head_id;
      assign p_tag = head_tag;
    end else begin : g_mid
      assign p_vld = c_vld[i-1];
      assign p_id  = c_id[i-1];
      assign p_tag = c_tag[i-1];
    end

    if (i == NUM_SLOTS - 1) begin : g_tail
      assign n_vld = 1'b0;
      assign n_id  = '0;
      assign n_tag = '0;
    end else begin : g_body
      assign n_vld = c_vld[i+1];
      assign n_id  = c_id[i+1];
      assign n_tag = c_tag[i+1];
    end

    lsm_cell #(
      .CELL_IDX (i),
      .SLOT_W   (SLOT_W),
      .TAG_W    (TAG_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .key_id      (key_id),
      .pos         (pos),
      .prev_valid  (p_vld),
      .prev_id     (p_id),
      .prev_tag    (p_tag),
      .next_valid  (n_vld),
      .next_id     (n_id),
      .next_tag    (n_tag),
      .seen_in     (seen[i]),
      .seen_out    (seen[i+1]),
      .sel_id_in   (sid[i]),
      .sel_tag_in  (stag[i]),
      .sel_id_out  (sid[i+1]),
      .sel_tag_out (stag[i+1]),
      .valid       (c_vld[i]),
      .id          (c_id[i]),
      .tag         (c_tag[i])
    );
  end

  assign found   = seen[NUM_SLOTS];
  assign sel_id  = sid[NUM_SLOTS];
  assign sel_tag = stag[NUM_SLOTS];

endmodule
`default_nettype wire

/* src/lru_slot_manager.sv */
// lru_slot_manager: top level, sequencer, slot-in-use bits and entry count.
// Depends on lsm_pkg and lsm_row (which builds the lsm_cell chain).
//
//   channel | direction | handshake             | word
//   in      | input     | in_valid / in_ready   | lsm_pkg::in_word_t
//   out     | output    | out_valid / out_ready | lsm_pkg::out_word_t
//   cfg     | input     | cfg_valid / cfg_ready | capacity, 5 bits
//
// Each word goes through accept, evaluate (cells mark their target) and apply
// (for a live action the row shifts one position; the result register loads).
// A waiting result does not block accept; a new word waits in apply until the
// output register frees. cfg_ready is always high.
// Reset (synchronous, rst_n low) empties the row, clears all in-use bits and
// sets capacity to 16; no clearing pass.
`default_nettype none
module lru_slot_manager #(
  parameter int NUM_SLOTS   = 16,
  parameter int OFFSET_BITS = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lsm_pkg::in_word_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lsm_pkg::out_word_t                    out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lsm_pkg::CAP_W-1:0]        cfg_data
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int TAG_W  = (OFFSET_BITS < lsm_pkg::OFF_W) ? OFFSET_BITS : lsm_pkg::OFF_W;
  localparam int CMP_W  = (CNT_W > lsm_pkg::CAP_W) ? CNT_W : lsm_pkg::CAP_W;
  localparam int IW     = ((SLOT_W > lsm_pkg::IDX_W) ? SLOT_W : lsm_pkg::IDX_W) + 1;

  lsm_pkg::state_t    state_r, state_nxt;
  lsm_pkg::in_word_t  item_r;
  lsm_pkg::act_t      act_r, act_nxt;
  lsm_pkg::out_word_t out_r, out_nxt;
  lsm_pkg::cell_ctl_t ctl;

  logic [lsm_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [NUM_SLOTS-1:0]      in_use_r, in_use_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      evict_r, evict_nxt;
  logic                      status_r, status_nxt;
  logic [SLOT_W-1:0]         free_r, free_nxt;
  logic                      by_key;
  logic [SLOT_W-1:0]         key_id;
  logic [CNT_W-1:0]          pos;
  logic [SLOT_W-1:0]         head_id;
  logic [TAG_W-1:0]          head_tag;
  logic                      found;
  logic [SLOT_W-1:0]         sel_id;
  logic [TAG_W-1:0]          sel_tag;
  logic [CMP_W-1:0]          cap_eff;
  logic [CMP_W-1:0]          cap_ext;
  logic [IW-1:0]             idx_ext;
  logic [IW-1:0]             slot_ext;
  logic                      idx_ok;
  logic                      apply_go;

  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(NUM_SLOTS)) begin
      cap_eff = CMP_W'(NUM_SLOTS);
    end else begin
      cap_eff = cap_ext;
    end
    idx_ext = IW'(item_r.slot_index);
    key_id  = idx_ext[SLOT_W-1:0];
    idx_ok  = (idx_ext < IW'(NUM_SLOTS)) && in_use_r[key_id];
    free_nxt = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_nxt = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    evict_nxt     = evict_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    in_use_nxt    = in_use_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    by_key        = 1'b0;
    pos           = count_r;
    head_id       = sel_id;
    head_tag      = sel_tag;
    slot_ext      = '0;
    apply_go      = 1'b0;
    ctl           = '{eval: 1'b0, apply: 1'b0, act: act_r, by_key: 1'b0};

    unique case (state_r)
      lsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lsm_pkg::ST_EVAL;
        end
      end
      lsm_pkg::ST_EVAL: begin
        evict_nxt  = 1'b0;
        status_nxt = 1'b0;
        act_nxt    = lsm_pkg::ACT_NONE;
        case (item_r.op)
          lsm_pkg::OP_ALLOC: begin
            act_nxt   = lsm_pkg::ACT_PROMOTE;
            evict_nxt = (CMP_W'(count_r) >= cap_eff) && (count_r != '0);
            pos       = evict_nxt ? (count_r - CNT_W'(1)) : count_r;
          end
          lsm_pkg::OP_TOUCH: begin
            by_key     = 1'b1;
            act_nxt    = idx_ok ? lsm_pkg::ACT_PROMOTE : lsm_pkg::ACT_NONE;
            status_nxt = !idx_ok;
          end
          lsm_pkg::OP_FREE: begin
            by_key     = 1'b1;
            act_nxt    = idx_ok ? lsm_pkg::ACT_REMOVE : lsm_pkg::ACT_NONE;
            status_nxt = !idx_ok;
          end
          default: begin
            status_nxt = 1'b1;
          end
        endcase
        ctl       = '{eval: 1'b1, apply: 1'b0, act: act_r, by_key: by_key};
        state_nxt = lsm_pkg::ST_APPLY;
      end
      lsm_pkg::ST_APPLY: begin
        apply_go = !out_valid_r || out_ready;
        out_nxt.evicted        = evict_r;
        out_nxt.evicted_offset = evict_r ? lsm_pkg::OFF_W'(sel_tag) : '0;
        out_nxt.status         = status_r;
        slot_ext               = IW'(item_r.slot_index);
        if (item_r.op == lsm_pkg::OP_ALLOC) begin
          head_id  = evict_r ? sel_id : free_r;
          head_tag = item_r.page_offset[TAG_W-1:0];
          slot_ext = IW'(head_id);
          if (apply_go && !evict_r) begin
            in_use_nxt[free_r] = 1'b1;
            count_nxt          = count_r + CNT_W'(1);
          end
        end else if (item_r.op != lsm_pkg::OP_TOUCH && item_r.op != lsm_pkg::OP_FREE) begin
          slot_ext = '0;
        end
        if (apply_go && act_r == lsm_pkg::ACT_REMOVE) begin
          in_use_nxt[key_id] = 1'b0;
          count_nxt          = count_r - CNT_W'(1);
        end
        out_nxt.result_slot = slot_ext[lsm_pkg::IDX_W-1:0];
        ctl = '{eval: 1'b0, apply: apply_go, act: act_r, by_key: 1'b0};
        if (apply_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = lsm_pkg::ST_IDLE;
        end else begin
          out_nxt = out_r;
        end
      end
      default: begin
        state_nxt = lsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsm_pkg::ST_IDLE;
      act_r       <= lsm_pkg::ACT_NONE;
      cap_r       <= lsm_pkg::CAP_RESET;
      count_r     <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      count_r     <= count_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (state_r == lsm_pkg::ST_EVAL) begin
      free_r <= free_nxt;
    end
    evict_r  <= evict_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  lsm_row #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W),
    .TAG_W     (TAG_W),
    .CNT_W     (CNT_W)
  ) u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .key_id   (key_id),
    .pos      (pos),
    .head_id  (head_id),
    .head_tag (head_tag),
    .found    (found),
    .sel_id   (sel_id),
    .sel_tag  (sel_tag)
  );

  assign in_ready  = (state_r == lsm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == 32'(count_r))
    else $error("entry count disagrees with in-use bits");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_SLOTS))
    else $error("entry count above slot count");

  a_target_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsm_pkg::ST_APPLY && act_r != lsm_pkg::ACT_NONE) |-> found)
    else $error("no cell marked for a live action");

  a_out_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lsm_pkg::ST_APPLY))
    else $error("result raised outside apply");

endmodule
`default_nettype wire

/* bench/tb_lru_slot_manager.sv */
// tb_lru_slot_manager: self-checking bench for the LRU slot manager (lru_slot_manager).
// Directed table plus random phases, checked against a recency-list predictor.
// Depends on lsm_pkg and the RTL under src.
`timescale 1ns / 1ps
module tb_lru_slot_manager;
  import lsm_pkg::*;

  localparam int NSLOT          = 16;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int NDIR           = 25;
  localparam int PHASE_ITEMS    = 55;

  localparam logic [OP_W-1:0]  OP_RSVD    = 2'd3;
  localparam logic [OFF_W-1:0] OFF_NEG1   = '1;
  localparam logic [OFF_W-1:0] OFF_MAXPOS = 48'h7FFF_FFFF_FFFF;
  localparam logic [OFF_W-1:0] OFF_MINNEG = 48'h8000_0000_0000;

  typedef struct packed {
    bit               cfg;
    logic [CAP_W-1:0] cap;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
    bit               known;
    logic [IDX_W-1:0] slot;
    bit               ev;
    logic [OFF_W-1:0] ev_off;
    bit               st;
  } step_row_t;

  typedef struct packed {
    bit        known;
    out_word_t word;
  } typed_result_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  // predictor state: newer = toward the most recent end
  logic [IDX_W-1:0] newer_nb [NSLOT];
  logic [IDX_W-1:0] older_nb [NSLOT];
  bit               has_newer [NSLOT];
  bit               has_older [NSLOT];
  bit               busy [NSLOT];
  logic [OFF_W-1:0] tag_mem [NSLOT];
  logic [IDX_W-1:0] mru_slot;
  logic [IDX_W-1:0] lru_slot;
  int               live_cnt;
  logic [CAP_W-1:0] cap_reg;

  out_word_t     slot_result_q [$];
  typed_result_t typed_result_q [$];

  int fail_cnt    = 0;
  int idle_cycles = 0;
  bit src_quiet   = 1'b0;
  bit snk_quiet   = 1'b0;
  bit long_hold   = 1'b0;

  step_row_t dir_rows [NDIR] = '{
    '{1'b0, 5'd0, OP_ALLOC, 4'd0, 48'd0, 1'b1, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd0, OFF_NEG1, 1'b1, 4'd1, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd15, OFF_MAXPOS, 1'b1, 4'd2, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_TOUCH, 4'd15, 48'd0, 1'b1, 4'd15, 1'b0, 48'd0, 1'b1},
    '{1'b0, 5'd0, OP_FREE, 4'd15, 48'd0, 1'b1, 4'd15, 1'b0, 48'd0, 1'b1},
    '{1'b0, 5'd0, OP_TOUCH, 4'd2, 48'd0, 1'b1, 4'd2, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_TOUCH, 4'd0, 48'd0, 1'b1, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_FREE, 4'd2, 48'd0, 1'b1, 4'd2, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd7, OFF_MINNEG, 1'b1, 4'd2, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_RSVD, 4'd9, OFF_NEG1, 1'b1, 4'd0, 1'b0, 48'd0, 1'b1},
    // capacity dropped below the live count
    '{1'b1, 5'd2, OP_ALLOC, 4'd0, 48'd0, 1'b0, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd0, 48'h1234, 1'b1, 4'd1, 1'b1, OFF_NEG1, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd0, 48'h5555_5555_5555, 1'b1, 4'd0, 1'b1, 48'd0, 1'b0},
    // zero capacity behaves as one
    '{1'b1, 5'd0, OP_ALLOC, 4'd0, 48'd0, 1'b0, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd0, 48'hAAAA_AAAA_AAAA, 1'b1, 4'd2, 1'b1, OFF_MINNEG, 1'b0},
    '{1'b0, 5'd0, OP_FREE, 4'd2, 48'd0, 1'b1, 4'd2, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_FREE, 4'd1, 48'd0, 1'b1, 4'd1, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_FREE, 4'd0, 48'd0, 1'b1, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_FREE, 4'd0, 48'd0, 1'b1, 4'd0, 1'b0, 48'd0, 1'b1},
    '{1'b0, 5'd0, OP_ALLOC, 4'd0, 48'd1, 1'b1, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd0, 48'd2, 1'b1, 4'd0, 1'b1, 48'd1, 1'b0},
    // above the slot count behaves as the slot count
    '{1'b1, 5'd31, OP_ALLOC, 4'd0, 48'd0, 1'b0, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd15, 48'h0F0F_0F0F_0F0F, 1'b0, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_TOUCH, 4'd0, 48'd0, 1'b0, 4'd0, 1'b0, 48'd0, 1'b0},
    '{1'b0, 5'd0, OP_ALLOC, 4'd0, OFF_MAXPOS, 1'b0, 4'd0, 1'b0, 48'd0, 1'b0}
  };

  logic [CAP_W-1:0] phase_caps [10] = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0,
                                        5'd8, 5'd2, 5'd16, 5'd12, 5'd3};

  lru_slot_manager #(
    .NUM_SLOTS   (NSLOT),
    .OFFSET_BITS (OFF_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void lru_unlink(input logic [IDX_W-1:0] s);
    if (has_newer[s]) begin
      has_older[newer_nb[s]] = has_older[s];
      older_nb[newer_nb[s]]  = older_nb[s];
    end else begin
      mru_slot = older_nb[s];
      if (has_older[s]) has_newer[mru_slot] = 1'b0;
    end
    if (has_older[s]) begin
      has_newer[older_nb[s]] = has_newer[s];
      newer_nb[older_nb[s]]  = newer_nb[s];
    end else begin
      lru_slot = newer_nb[s];
      if (has_newer[s]) has_older[lru_slot] = 1'b0;
    end
    if (!has_newer[s] && !has_older[s]) begin
      mru_slot = '0;
      lru_slot = '0;
    end
    has_newer[s] = 1'b0;
    has_older[s] = 1'b0;
  endfunction

  function automatic void lru_link_mru(input logic [IDX_W-1:0] s, input bit was_empty);
    has_newer[s] = 1'b0;
    if (was_empty) begin
      has_older[s] = 1'b0;
      lru_slot     = s;
    end else begin
      older_nb[s]         = mru_slot;
      has_older[s]        = 1'b1;
      newer_nb[mru_slot]  = s;
      has_newer[mru_slot] = 1'b1;
    end
    mru_slot = s;
  endfunction

  function automatic out_word_t lru_predict(input in_word_t w);
    out_word_t        r;
    int               eff_cap;
    logic [IDX_W-1:0] s;
    bit               found;
    r = '0;
    r.result_slot = w.slot_index;
    if (w.op == OP_ALLOC) begin
      eff_cap = (cap_reg == 0) ? 1 : (cap_reg > NSLOT) ? NSLOT : int'(cap_reg);
      if (live_cnt >= eff_cap && live_cnt > 0) begin
        s = lru_slot;
        r.evicted = 1'b1;
        r.evicted_offset = tag_mem[s];
        lru_unlink(s);
        busy[s] = 1'b0;
        live_cnt--;
      end else begin
        s = '0;
        found = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
          if (!found && !busy[i]) begin
            s = 4'(i);
            found = 1'b1;
          end
        end
      end
      tag_mem[s] = w.page_offset;
      busy[s] = 1'b1;
      lru_link_mru(s, live_cnt == 0);
      live_cnt++;
      r.result_slot = s;
    end else if (w.op == OP_TOUCH || w.op == OP_FREE) begin
      if (!busy[w.slot_index]) begin
        r.status = 1'b1;
      end else if (w.op == OP_TOUCH) begin
        if (has_newer[w.slot_index]) begin
          lru_unlink(w.slot_index);
          lru_link_mru(w.slot_index, 1'b0);
        end
      end else begin
        lru_unlink(w.slot_index);
        busy[w.slot_index] = 1'b0;
        live_cnt--;
      end
    end else begin
      r.result_slot = '0;
      r.status = 1'b1;
    end
    return r;
  endfunction

  // mostly names slots that are live, so touch and free reach the list
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    int       live [$];
    pick = $urandom_range(0, 99);
    if (pick < 45) w.op = OP_ALLOC;
    else if (pick < 75) w.op = OP_TOUCH;
    else if (pick < 95) w.op = OP_FREE;
    else w.op = OP_RSVD;
    for (int i = 0; i < NSLOT; i++) begin
      if (busy[i]) live.push_back(i);
    end
    if (live.size() != 0 && $urandom_range(0, 4) != 0)
      w.slot_index = 4'(live[$urandom_range(0, live.size() - 1)]);
    else
      w.slot_index = 4'($urandom_range(0, NSLOT - 1));
    case ($urandom_range(0, 9))
      0: w.page_offset = OFF_NEG1;
      1: w.page_offset = '0;
      2: w.page_offset = OFF_MAXPOS;
      3: w.page_offset = OFF_MINNEG;
      default: w.page_offset = {16'($urandom), 32'($urandom)};
    endcase
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit known, input out_word_t r);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 17);
    typed_result_q.push_back('{known, r});
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (slot_result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_word_t  w;
    out_word_t typed;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].cfg) begin
        set_capacity(dir_rows[k].cap);
      end else begin
        w = '{op: dir_rows[k].op, slot_index: dir_rows[k].idx, page_offset: dir_rows[k].off};
        typed = '{result_slot: dir_rows[k].slot, evicted: dir_rows[k].ev,
                  evicted_offset: dir_rows[k].ev_off, status: dir_rows[k].st};
        send_word(w, dir_rows[k].known, typed);
      end
    end

    for (int p = 0; p < 10; p++) begin
      set_capacity(phase_caps[p]);
      src_quiet = (p % 2 == 1);
      snk_quiet = (p % 3 == 2);
      // receiver stops for a long stretch while words keep coming
      if (p == 3) long_hold = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 6 && n == PHASE_ITEMS / 2) settle();
        send_word(random_word(), 1'b0, '0);
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (fail_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        stall = (snk_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    typed_result_t tr;
    out_word_t     pred;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        newer_nb[i]  = '0;
        older_nb[i]  = '0;
        has_newer[i] = 1'b0;
        has_older[i] = 1'b0;
        busy[i]      = 1'b0;
        tag_mem[i]   = '0;
      end
      mru_slot = '0;
      lru_slot = '0;
      live_cnt = 0;
      cap_reg  = CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (in_valid && in_ready) begin
        pred = lru_predict(in_data);
        tr = typed_result_q.pop_front();
        slot_result_q.push_back(tr.known ? tr.word : pred);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (slot_result_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        fail_cnt++;
      end else begin
        want = slot_result_q.pop_front();
        if (out_data.result_slot !== want.result_slot) begin
          $error("result_slot: expected %0d, got %0d", want.result_slot, out_data.result_slot);
          fail_cnt++;
        end
        if (out_data.evicted !== want.evicted) begin
          $error("evicted: expected %0b, got %0b", want.evicted, out_data.evicted);
          fail_cnt++;
        end
        if (out_data.evicted_offset !== want.evicted_offset) begin
          $error("evicted_offset: expected %h, got %h",
                 want.evicted_offset, out_data.evicted_offset);
          fail_cnt++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, out_data.status);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

/* files.f */
src/lsm_pkg.sv
src/lsm_cell.sv
src/lsm_row.sv
src/lru_slot_manager.sv
bench/tb_lru_slot_manager.sv
